// ===== sv/ipv4hc_pkg.sv =====
// Shared types, constants and helpers for the IPv4 header receive check.
package ipv4hc_pkg;

    localparam int unsigned CFG_INDEX_W = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOCAL_ADDRESS = 8'd0,
        CFG_MAX_PAYLOAD   = 8'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_UDP         = 3'd0,
        VERDICT_ICMP        = 3'd1,
        VERDICT_PROTO_UNRCH = 3'd2,
        VERDICT_BAD_VERSION = 3'd3,
        VERDICT_BAD_IHL     = 3'd4,
        VERDICT_TOO_BIG_DF  = 3'd5,
        VERDICT_BAD_CSUM    = 3'd6,
        VERDICT_NOT_OURS    = 3'd7
    } verdict_t;

    localparam logic [3:0]  IP_VERSION      = 4'd4;
    localparam logic [5:0]  HDR_MIN         = 6'd20;
    localparam logic [5:0]  HDR_MAX         = 6'd60;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1500;

    // Byte positions within the header
    localparam logic [5:0] IDX_TLEN_HI  = 6'd2;
    localparam logic [5:0] IDX_TLEN_LO  = 6'd3;
    localparam logic [5:0] IDX_FLAGS    = 6'd6;
    localparam logic [5:0] IDX_PROTO    = 6'd9;
    localparam logic [5:0] IDX_CSUM_LO  = 6'd11;
    localparam logic [5:0] IDX_SRC_LO   = 6'd12;
    localparam logic [5:0] IDX_SRC_HI   = 6'd15;
    localparam logic [5:0] IDX_DST_LO   = 6'd16;
    localparam logic [5:0] IDX_DST_HI   = 6'd19;

    typedef struct packed {
        verdict_t    verdict;
        logic [5:0]  header_bytes;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
    } result_t;

    // Ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== sv/ipv4_header_receive_check_top.sv =====
// IPv4 header receive check: byte-wide header parse, checksum and verdict.
// A verdict is registered on the last header byte, or on a first byte that
// fails the version or length check. Throughput: one byte per cycle while
// the skid stage is empty; a two-deep output (register plus skid) lets the
// input keep flowing while a verdict waits to be taken.
// Reset: aresetn (synchronous, active low) clears the parser, empties the
// output and loads local_address = 0, max_payload = 1500.
module ipv4_header_receive_check_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_first_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_verdict,
    output logic [5:0]                      m_header_bytes,
    output logic [31:0]                     m_source_address,
    output logic [7:0]                      m_protocol_number,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipv4hc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import ipv4hc_pkg::*;

    logic [31:0] local_address_reg;
    logic [15:0] max_payload_reg;

    logic        active_reg, active_next;
    logic [5:0]  byte_count_reg, byte_count_next;
    logic [5:0]  header_length_reg, header_length_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [15:0] total_length_reg, total_length_next;
    logic        dont_fragment_reg, dont_fragment_next;
    logic [15:0] stored_csum_reg, stored_csum_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;

    logic        m_valid_reg, m_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        in_accept;
    logic        out_take;
    logic        gen_result;
    result_t     res;
    logic [5:0]  hb;
    logic [15:0] word;
    logic [15:0] payload_len;
    logic        too_big;

    assign s_ready   = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_take  = m_valid_reg && m_ready;

    assign m_valid           = m_valid_reg;
    assign m_verdict         = out_reg.verdict;
    assign m_header_bytes    = out_reg.header_bytes;
    assign m_source_address  = out_reg.source_address;
    assign m_protocol_number = out_reg.protocol_number;

    assign hb   = {s_data_byte[3:0], 2'b00};
    assign word = {high_byte_reg, s_data_byte};

    // Parser and verdict
    always_comb begin
        active_next        = active_reg;
        byte_count_next    = byte_count_reg;
        header_length_next = header_length_reg;
        sum_next           = sum_reg;
        high_byte_next     = high_byte_reg;
        total_length_next  = total_length_reg;
        dont_fragment_next = dont_fragment_reg;
        stored_csum_next   = stored_csum_reg;
        protocol_next      = protocol_reg;
        source_next        = source_reg;
        dest_next          = dest_reg;
        gen_result         = 1'b0;
        res                = '0;
        payload_len        = total_length_reg - {10'd0, header_length_reg};
        too_big            = 1'b0;

        if (in_accept) begin
            if (s_first_byte) begin
                active_next = 1'b0;
                if (s_data_byte[7:4] != IP_VERSION) begin
                    gen_result       = 1'b1;
                    res.verdict      = VERDICT_BAD_VERSION;
                    res.header_bytes = hb;
                end else if (hb < HDR_MIN || hb > HDR_MAX) begin
                    gen_result       = 1'b1;
                    res.verdict      = VERDICT_BAD_IHL;
                    res.header_bytes = hb;
                end else begin
                    active_next        = 1'b1;
                    header_length_next = hb;
                    byte_count_next    = 6'd1;
                    sum_next           = '0;
                    high_byte_next     = s_data_byte;
                    total_length_next  = '0;
                    dont_fragment_next = 1'b0;
                    stored_csum_next   = '0;
                    protocol_next      = '0;
                    source_next        = '0;
                    dest_next          = '0;
                end
            end else if (active_reg) begin
                if (!byte_count_reg[0]) begin
                    high_byte_next = s_data_byte;
                end else if (byte_count_reg == IDX_CSUM_LO) begin
                    stored_csum_next = word;
                end else begin
                    sum_next = ones_add(sum_reg, word);
                end

                if (byte_count_reg == IDX_TLEN_HI || byte_count_reg == IDX_TLEN_LO) begin
                    total_length_next = {total_length_reg[7:0], s_data_byte};
                end else if (byte_count_reg == IDX_FLAGS) begin
                    dont_fragment_next = s_data_byte[6];
                end else if (byte_count_reg == IDX_PROTO) begin
                    protocol_next = s_data_byte;
                end else if (byte_count_reg >= IDX_SRC_LO && byte_count_reg <= IDX_SRC_HI) begin
                    source_next = {source_reg[23:0], s_data_byte};
                end else if (byte_count_reg >= IDX_DST_LO && byte_count_reg <= IDX_DST_HI) begin
                    dest_next = {dest_reg[23:0], s_data_byte};
                end

                byte_count_next = byte_count_reg + 6'd1;

                // Last header byte: total length and flags are settled by now
                if (byte_count_next == header_length_reg) begin
                    active_next = 1'b0;
                    gen_result  = 1'b1;
                    too_big     = dont_fragment_reg &&
                                  (total_length_reg > {10'd0, header_length_reg}) &&
                                  (payload_len > max_payload_reg);
                    res.header_bytes    = header_length_reg;
                    res.source_address  = source_next;
                    res.protocol_number = protocol_next;
                    if (too_big) begin
                        res.verdict = VERDICT_TOO_BIG_DF;
                    end else if (~sum_next != stored_csum_next) begin
                        res.verdict = VERDICT_BAD_CSUM;
                    end else if (dest_next != local_address_reg) begin
                        res.verdict = VERDICT_NOT_OURS;
                    end else if (protocol_next == PROTO_UDP) begin
                        res.verdict = VERDICT_UDP;
                    end else if (protocol_next == PROTO_ICMP) begin
                        res.verdict = VERDICT_ICMP;
                    end else begin
                        res.verdict = VERDICT_PROTO_UNRCH;
                    end
                end
            end
        end
    end

    // Output register and skid stage
    always_comb begin
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (out_take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (gen_result) begin
            if (!m_valid_reg || out_take) begin
                out_next     = res;
                m_valid_next = 1'b1;
            end else begin
                // Hold the word until the output register frees
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
            skid_valid_reg    <= 1'b0;
            local_address_reg <= '0;
            max_payload_reg   <= MAX_PAYLOAD_RST;
        end else begin
            active_reg     <= active_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                    CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_count_reg    <= byte_count_next;
        header_length_reg <= header_length_next;
        sum_reg           <= sum_next;
        high_byte_reg     <= high_byte_next;
        total_length_reg  <= total_length_next;
        dont_fragment_reg <= dont_fragment_next;
        stored_csum_reg   <= stored_csum_next;
        protocol_reg      <= protocol_next;
        source_reg        <= source_next;
        dest_reg          <= dest_next;
        out_reg           <= out_next;
        skid_reg          <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid stage full while output register empty");

    a_active_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (byte_count_reg < header_length_reg))
        else $error("byte count ran past header length");

    a_active_length: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (header_length_reg >= HDR_MIN && header_length_reg <= HDR_MAX))
        else $error("active with header length out of range");

    a_bad_version_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_first_byte && s_data_byte[7:4] != IP_VERSION) |=> m_valid_reg)
        else $error("bad version byte gave no verdict");

endmodule
